/* rtl/sset_pkg.sv */
package sset_pkg;

   // Store geometry
   localparam int ENTITY_COUNT = 256;
   localparam int DATA_WIDTH   = 64;
   localparam int IDX_W        = $clog2(ENTITY_COUNT);
   localparam int CNT_W        = IDX_W + 1;

   // Channel field widths
   localparam int MODE_W   = 2;
   localparam int ENTITY_W = 8;
   localparam int SLOT_W   = 8;
   localparam int DIN_W    = 64;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_SLOT   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED    = 3'd0,
      ST_OVERWRITTEN = 3'd1,
      ST_REMOVED     = 3'd2,
      ST_ABSENT      = 3'd3,
      ST_FOUND       = 3'd4
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;     // capture request word
      logic rd_issue;  // first memory read
      logic exec;      // decide, write back, load response
      logic fetch;     // load data of a lookup hit
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_fetch;
   } stat_type;

endpackage

/* rtl/sset_if.sv */
interface sset_req_if;
   logic                           valid;
   logic                           ready;
   logic [sset_pkg::MODE_W-1:0]    mode;
   logic [sset_pkg::ENTITY_W-1:0]  entity;
   logic [sset_pkg::SLOT_W-1:0]    slot;
   logic [sset_pkg::DIN_W-1:0]     data_in;

   modport source (output valid, output mode, output entity, output slot, output data_in,
                   input ready);
   modport sink   (input valid, input mode, input entity, input slot, input data_in,
                   output ready);
endinterface

interface sset_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sset_pkg::STATUS_W-1:0]  status;
   logic [sset_pkg::DIN_W-1:0]     data_out;
   logic [sset_pkg::ENTITY_W-1:0]  entity_out;
   logic [sset_pkg::SLOT_W-1:0]    slot_out;
   logic [sset_pkg::LIVE_W-1:0]    live_count;

   modport source (output valid, output status, output data_out, output entity_out,
                   output slot_out, output live_count, input ready);
   modport sink   (input valid, input status, input data_out, input entity_out,
                   input slot_out, input live_count, output ready);
endinterface

/* rtl/sset_ctrl.sv */
module sset_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  sset_pkg::stat_type stat,
   output sset_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_EXEC  = 5'b00100,
      S_FETCH = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = stat.need_fetch ? S_FETCH : S_RESP;
         S_FETCH: state_in = S_RESP;
         S_RESP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = (state_ff == S_RESP);
   assign cmd.latch    = (state_ff == S_IDLE) && req_valid;
   assign cmd.rd_issue = (state_ff == S_READ);
   assign cmd.exec     = (state_ff == S_EXEC);
   assign cmd.fetch    = (state_ff == S_FETCH);

endmodule

/* rtl/sset_dp.sv */
module sset_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  sset_pkg::cmd_type                cmd,
   output sset_pkg::stat_type               stat,
   input  logic [sset_pkg::MODE_W-1:0]      req_mode,
   input  logic [sset_pkg::ENTITY_W-1:0]    req_entity,
   input  logic [sset_pkg::SLOT_W-1:0]      req_slot,
   input  logic [sset_pkg::DIN_W-1:0]       req_data_in,
   output logic [sset_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sset_pkg::DIN_W-1:0]       rsp_data_out,
   output logic [sset_pkg::ENTITY_W-1:0]    rsp_entity_out,
   output logic [sset_pkg::SLOT_W-1:0]      rsp_slot_out,
   output logic [sset_pkg::LIVE_W-1:0]      rsp_live_count
);

   // Request word
   sset_pkg::mode_type                  mode_ff;
   logic [sset_pkg::ENTITY_W-1:0]       ent_ff;
   logic [sset_pkg::SLOT_W-1:0]         slot_ff;
   logic [sset_pkg::DATA_WIDTH-1:0]     din_ff;

   logic [sset_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [sset_pkg::ENTITY_COUNT-1:0]   valid_ff;

   // Tables
   logic [sset_pkg::IDX_W-1:0]          sparse_mem [sset_pkg::ENTITY_COUNT];
   logic [sset_pkg::IDX_W-1:0]          dense_mem  [sset_pkg::ENTITY_COUNT];
   logic [sset_pkg::DATA_WIDTH-1:0]     data_mem   [sset_pkg::ENTITY_COUNT];

   // Registered read data
   logic [sset_pkg::IDX_W-1:0]          sparse_q, dense_q;
   logic [sset_pkg::DATA_WIDTH-1:0]     data_q;
   logic                                vld_q;

   // Response word
   sset_pkg::status_type                status_ff;
   logic [sset_pkg::DATA_WIDTH-1:0]     dout_ff;
   logic [sset_pkg::IDX_W-1:0]          eout_ff, sout_ff;

   logic [sset_pkg::IDX_W-1:0]          ent_idx, slot_idx, last_idx, tail_idx, aux_addr;
   logic [sset_pkg::IDX_W-1:0]          data_raddr;
   logic                                ent_ok, slot_ok, hit, room;

   sset_pkg::status_type                status_c;
   logic [sset_pkg::DATA_WIDTH-1:0]     dout_c;
   logic [sset_pkg::IDX_W-1:0]          eout_c, sout_c;
   logic                                need_fetch_c;

   logic                                sparse_we, dense_we, data_we, valid_set, valid_clr;
   logic [sset_pkg::IDX_W-1:0]          sparse_wa, sparse_wd, dense_wa, dense_wd, data_wa;
   logic [sset_pkg::DATA_WIDTH-1:0]     data_wd;

   assign ent_idx  = sset_pkg::IDX_W'(ent_ff);
   assign slot_idx = sset_pkg::IDX_W'(slot_ff);
   assign tail_idx = sset_pkg::IDX_W'(count_ff);
   assign last_idx = sset_pkg::IDX_W'(count_ff - sset_pkg::CNT_W'(1));
   assign ent_ok   = 32'(ent_ff) < sset_pkg::ENTITY_COUNT;
   assign slot_ok  = 32'(slot_ff) < 32'(count_ff);
   assign room     = 32'(count_ff) < sset_pkg::ENTITY_COUNT;
   assign hit      = ent_ok && vld_q && (32'(sparse_q) < 32'(count_ff));

   // Read-slot reads the addressed slot; remove reads the tail to fill the hole
   assign aux_addr   = (mode_ff == sset_pkg::MODE_SLOT) ? slot_idx : last_idx;
   assign data_raddr = cmd.exec ? sparse_q : aux_addr;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= sset_pkg::mode_type'(req_mode);
         ent_ff  <= req_entity;
         slot_ff <= req_slot;
         din_ff  <= sset_pkg::DATA_WIDTH'(req_data_in);
      end
   end

   // Memory reads
   always_ff @(posedge clock) begin
      if (cmd.rd_issue) begin
         sparse_q <= sparse_mem[ent_idx];
         dense_q  <= dense_mem[aux_addr];
         vld_q    <= valid_ff[ent_idx];
      end
      if (cmd.rd_issue || cmd.exec) begin
         data_q <= data_mem[data_raddr];
      end
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (sparse_we) sparse_mem[sparse_wa] <= sparse_wd;
      if (dense_we)  dense_mem[dense_wa]   <= dense_wd;
      if (data_we)   data_mem[data_wa]     <= data_wd;
   end

   always_comb begin
      status_c     = sset_pkg::ST_ABSENT;
      dout_c       = '0;
      eout_c       = ent_idx;
      sout_c       = '0;
      count_in     = count_ff;
      need_fetch_c = 1'b0;
      sparse_we    = 1'b0;
      sparse_wa    = ent_idx;
      sparse_wd    = tail_idx;
      dense_we     = 1'b0;
      dense_wa     = tail_idx;
      dense_wd     = ent_idx;
      data_we      = 1'b0;
      data_wa      = tail_idx;
      data_wd      = din_ff;
      valid_set    = 1'b0;
      valid_clr    = 1'b0;
      case (mode_ff)
         sset_pkg::MODE_ADD: begin
            if (hit) begin
               data_we  = cmd.exec;
               data_wa  = sparse_q;
               status_c = sset_pkg::ST_OVERWRITTEN;
               sout_c   = sparse_q;
            end else if (ent_ok && room) begin
               data_we   = cmd.exec;
               dense_we  = cmd.exec;
               sparse_we = cmd.exec;
               valid_set = cmd.exec;
               count_in  = count_ff + sset_pkg::CNT_W'(1);
               status_c  = sset_pkg::ST_INSERTED;
               sout_c    = tail_idx;
            end
         end
         sset_pkg::MODE_REMOVE: begin
            if (hit) begin
               // tail entry moves into the hole; if it is the removed one the
               // valid clear below wins
               dense_we  = cmd.exec;
               dense_wa  = sparse_q;
               dense_wd  = dense_q;
               data_we   = cmd.exec;
               data_wa   = sparse_q;
               data_wd   = data_q;
               sparse_we = cmd.exec;
               sparse_wa = dense_q;
               sparse_wd = sparse_q;
               valid_clr = cmd.exec;
               count_in  = count_ff - sset_pkg::CNT_W'(1);
               status_c  = sset_pkg::ST_REMOVED;
               sout_c    = sparse_q;
            end
         end
         sset_pkg::MODE_LOOKUP: begin
            if (hit) begin
               status_c     = sset_pkg::ST_FOUND;
               sout_c       = sparse_q;
               need_fetch_c = 1'b1;
            end
         end
         sset_pkg::MODE_SLOT: begin
            eout_c = '0;
            if (slot_ok) begin
               status_c = sset_pkg::ST_FOUND;
               dout_c   = data_q;
               eout_c   = dense_q;
               sout_c   = slot_idx;
            end
         end
         default: begin
            status_c = sset_pkg::ST_ABSENT;
         end
      endcase
   end

   assign stat.need_fetch = need_fetch_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         if (cmd.exec) count_ff <= count_in;
         if (valid_set) valid_ff[ent_idx] <= 1'b1;
         if (valid_clr) valid_ff[ent_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_c;
         dout_ff   <= dout_c;
         eout_ff   <= eout_c;
         sout_ff   <= sout_c;
      end
      if (cmd.fetch) begin
         dout_ff <= data_q;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_data_out   = sset_pkg::DIN_W'(dout_ff);
   assign rsp_entity_out = sset_pkg::ENTITY_W'(eout_ff);
   assign rsp_slot_out   = sset_pkg::SLOT_W'(sout_ff);
   assign rsp_live_count = sset_pkg::LIVE_W'(count_ff);

endmodule

/* rtl/sparse_set_component_store.sv */
// Sparse-set store keeping one data word per entity id, with packed dense
// slots for iteration. One word is handled at a time: a request is taken in
// the idle cycle, the sparse, dense and data tables are read in the next, the
// result is decided and written back in the exec state, and the response is
// shown from the response state until it is taken. A lookup that hits also
// passes through a fetch state, as the single read port of the data table
// needs a second access once the slot is known. The valid marks of the
// sparse table sit in flops cleared by reset, so the block is usable
// straight after reset with no clearing pass.
module sparse_set_component_store (
   input  logic        clock,
   input  logic        reset,
   sset_req_if.sink    req_if,
   sset_rsp_if.source  rsp_if
);

   sset_pkg::cmd_type  cmd;
   sset_pkg::stat_type stat;

   sset_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sset_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_if.mode),
      .req_entity     (req_if.entity),
      .req_slot       (req_if.slot),
      .req_data_in    (req_if.data_in),
      .rsp_status     (rsp_if.status),
      .rsp_data_out   (rsp_if.data_out),
      .rsp_entity_out (rsp_if.entity_out),
      .rsp_slot_out   (rsp_if.slot_out),
      .rsp_live_count (rsp_if.live_count)
   );

endmodule

/* rtl/sset_checker.sv */
module sset_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [sset_pkg::STATUS_W-1:0]   rsp_status,
   input logic [sset_pkg::DIN_W-1:0]      rsp_data_out,
   input logic [sset_pkg::LIVE_W-1:0]     rsp_live_count
);

   logic                          seen_ff;
   logic [sset_pkg::LIVE_W-1:0]   prev_cnt_ff;
   logic [sset_pkg::LIVE_W-1:0]   expect_cnt;
   logic                          rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      expect_cnt = prev_cnt_ff;
      if (rsp_status == sset_pkg::ST_INSERTED) begin
         expect_cnt = prev_cnt_ff + sset_pkg::LIVE_W'(1);
      end else if (rsp_status == sset_pkg::ST_REMOVED) begin
         expect_cnt = prev_cnt_ff - sset_pkg::LIVE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= 1'b0;
         prev_cnt_ff <= '0;
      end else if (rsp_fire) begin
         seen_ff     <= 1'b1;
         prev_cnt_ff <= rsp_live_count;
      end
   end

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_data_out) && $stable(rsp_live_count))
      else $error("response changed while stalled");

   // only one word in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // count moves by one on insert and remove only
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && seen_ff |-> rsp_live_count == expect_cnt)
      else $error("live count inconsistent with status");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sset_pkg::ST_INSERTED
         || rsp_status == sset_pkg::ST_OVERWRITTEN
         || rsp_status == sset_pkg::ST_REMOVED
         || rsp_status == sset_pkg::ST_ABSENT) |-> rsp_data_out == '0)
      else $error("data returned on non-found status");

endmodule

bind sparse_set_component_store sset_checker u_sset_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_data_out   (rsp_if.data_out),
   .rsp_live_count (rsp_if.live_count)
);
